// ===== sv/ltmv_pkg.sv =====
// Shared widths and types for the lower-triangular matrix-vector accumulate unit.
package ltmv_pkg;

  localparam int VAL_W        = 32;          // Q16.16 data
  localparam int ACC_W        = 48;          // Q32.16 accumulator
  localparam int FRAC_W       = 16;
  localparam int PROD_W       = 2 * VAL_W;   // full Q32.32 product
  localparam int IDX_W        = 6;
  localparam int SIZE_W       = 7;
  localparam int DEF_MAX_SIZE = 64;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  // input beat kinds
  typedef enum logic [1:0] {K_LOAD, K_PRESET, K_MATRIX, K_READ} kind_t;

endpackage

// ===== sv/ltmv_mac.sv =====
// Multiply with registered product, floor to Q32.16, saturating 48-bit accumulate.
module ltmv_mac import ltmv_pkg::*; (
  input  logic clk,
  input  logic mul_en,
  input  val_t a,
  input  val_t b,
  input  acc_t acc,
  output acc_t sum
);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_shr;
  logic signed [ACC_W:0]    wide;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= a * b;
    end
  end

  // arithmetic shift is floor; result fits in 47 bits plus sign
  assign prod_shr = prod >>> FRAC_W;
  assign wide     = $signed({acc[ACC_W-1], acc}) + $signed(prod_shr[ACC_W:0]);

  always_comb begin
    if (wide[ACC_W] != wide[ACC_W-1]) begin
      sum = wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sum = wide[ACC_W-1:0];
    end
  end

endmodule

// ===== sv/lower_triangular_matvec_accumulate_unit.sv =====
// Top level: y += L*b over a vector memory and an accumulator memory.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-----------------------------
//  in       | input     | in_valid / in_ready | kind, row, col, value
//  out      | output    | out_valid/out_ready | out_index, out_sum
//  cfg      | input     | cfg_we (no wait)    | cfg_wdata (matrix_size)
//
// Vector loads, presets and skipped matrix elements finish in S_IDLE; reads
// pass through S_READ; matrix elements pass through S_READ and S_WB for the read,
// multiply and write-back through the single accumulator write port. After reset
// the accumulators are zeroed, one entry a cycle, with in_ready low. A read waits
// in place while the output beat stalls.
module lower_triangular_matvec_accumulate_unit import ltmv_pkg::*; #(
  parameter int MAX_SIZE = DEF_MAX_SIZE
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              kind,
  input  logic [IDX_W-1:0]        row,
  input  logic [IDX_W-1:0]        col,
  input  logic signed [VAL_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [IDX_W-1:0]        out_index,
  output logic signed [ACC_W-1:0] out_sum,
  input  logic                    cfg_we,
  input  logic [SIZE_W-1:0]       cfg_wdata
);

  localparam int AW = $clog2(MAX_SIZE);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_WB} state_t;

  state_t            state;
  kind_t             in_kind;
  kind_t             item_kind;
  logic [IDX_W-1:0]  item_row;
  logic [AW-1:0]     item_addr;
  logic              item_row_ok;
  val_t              item_val;
  logic              clearing;
  logic [AW-1:0]     clr_addr;
  logic [SIZE_W-1:0] matrix_size;

  logic          accept;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] col_addr;
  logic          in_row_ok;
  logic          in_col_ok;
  logic          mat_hit;
  logic          mul_en;
  logic          out_load;

  val_t vec_mem [MAX_SIZE];
  acc_t acc_mem [MAX_SIZE];
  val_t vec_rd;
  acc_t acc_rd;

  logic          acc_we;
  logic [AW-1:0] acc_waddr;
  acc_t          acc_wdata;
  acc_t          mac_sum;

  assign in_kind   = kind_t'(kind);
  assign in_ready  = (state == S_IDLE) && !clearing;
  assign accept    = in_valid && in_ready;
  assign in_addr   = AW'(row);
  assign col_addr  = AW'(col);
  assign in_row_ok = 32'(row) < MAX_SIZE;
  assign in_col_ok = 32'(col) < MAX_SIZE;
  // col <= row together with row < size covers col < size
  assign mat_hit   = (col <= row) && ({1'b0, row} < matrix_size) && in_row_ok && in_col_ok;
  assign mul_en    = (state == S_READ) && (item_kind == K_MATRIX);
  // read result moves into the output register this cycle
  assign out_load  = (state == S_READ) && (item_kind == K_READ) && (!out_valid || out_ready);

  ltmv_mac u_mac (
    .clk    (clk),
    .mul_en (mul_en),
    .a      (item_val),
    .b      (vec_rd),
    .acc    (acc_rd),
    .sum    (mac_sum)
  );

  // accumulator write port: clear sweep, preset, or MAC write-back
  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = clr_addr;
    acc_wdata = '0;
    priority if (clearing) begin
      acc_we = 1'b1;
    end else if (accept && in_kind == K_PRESET && in_row_ok) begin
      acc_we    = 1'b1;
      acc_waddr = in_addr;
      acc_wdata = ACC_W'(value);
    end else if (state == S_WB) begin
      acc_we    = 1'b1;
      acc_waddr = item_addr;
      acc_wdata = mac_sum;
    end else begin
      acc_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    if (accept) begin
      acc_rd <= acc_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_kind == K_LOAD && in_row_ok) begin
      vec_mem[in_addr] <= value;
    end
    if (accept) begin
      vec_rd <= vec_mem[col_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      clearing    <= 1'b1;
      clr_addr    <= '0;
      matrix_size <= SIZE_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        matrix_size <= cfg_wdata;
      end
      if (clearing) begin
        if (clr_addr == AW'(MAX_SIZE - 1)) begin
          clearing <= 1'b0;
        end else begin
          clr_addr <= clr_addr + 1'b1;
        end
      end
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            item_kind   <= in_kind;
            item_row    <= row;
            item_addr   <= in_addr;
            item_row_ok <= in_row_ok;
            item_val    <= value;
            if ((in_kind == K_MATRIX && mat_hit) || in_kind == K_READ) begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          if (item_kind == K_MATRIX) begin
            state <= S_WB;
          end else if (out_load) begin
            out_valid <= 1'b1;
            out_index <= item_row;
            out_sum   <= item_row_ok ? acc_rd : '0;
            state     <= S_IDLE;
          end
        end
        S_WB: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_wb_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_WB |-> item_row_ok && !clearing)
    else $error("write-back to out-of-range row or during clear");

  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_READ || state == S_IDLE)
    else $error("accepted beat did not enter read or finish");

  a_read_holds: assert property (@(posedge clk) disable iff (rst)
    state == S_READ && item_kind == K_READ && out_valid && !out_ready
      |=> state == S_READ && $stable(acc_rd))
    else $error("stalled read lost its data");

endmodule

// ===== test/tb.sv =====
// Testbench for the lower-triangular matrix-vector accumulate unit: directed and random beats.
`timescale 1ns / 1ps

module tb import ltmv_pkg::*; ();

  typedef struct packed {
    kind_t            op;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
    val_t             v;
    bit               pinned;
    acc_t             sum;
  } step_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    acc_t             sum;
  } readback_t;

  localparam int NUM_ENTRIES = DEF_MAX_SIZE;
  localparam logic signed [63:0] ACC_HI = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
  localparam logic signed [63:0] ACC_LO = -(64'sd1 <<< (ACC_W - 1));
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 300;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              kind;
  logic [IDX_W-1:0]        row;
  logic [IDX_W-1:0]        col;
  logic signed [VAL_W-1:0] value;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [IDX_W-1:0]        out_index;
  logic signed [ACC_W-1:0] out_sum;
  logic                    cfg_we;
  logic [SIZE_W-1:0]       cfg_wdata;

  // typed-in expectation riding along with the offered beat
  logic pin_en;
  acc_t pin_sum;

  // predictor state
  val_t              vec_mem [NUM_ENTRIES]     = '{default: '0};
  bit                vec_written [NUM_ENTRIES] = '{default: 1'b0};
  acc_t              acc_mem [NUM_ENTRIES]     = '{default: '0};
  logic [SIZE_W-1:0] size_reg                  = SIZE_RESET;

  readback_t readback_q [$];

  int errors = 0;
  int n_in   = 0;
  int n_out  = 0;
  int n_mac  = 0;
  int n_sat  = 0;
  int send_idle_pct, recv_idle_pct;
  int stall_reqs  = 0;   // bumped by the stimulus
  int stall_taken = 0;   // owned by the receiver
  int hold_left   = 0;

  // short directed walk; sums typed in where obvious, the rest predicted
  step_t plan [0:20] = '{
    '{K_READ,     6'd0,  6'd0,  32'h0000_0000, 1'b1, 48'h0000_0000_0000},
    '{K_READ,     6'd63, 6'd0,  32'h0000_0000, 1'b1, 48'h0000_0000_0000},
    '{K_LOAD,     6'd0,  6'd0,  32'h7FFF_FFFF, 1'b0, 48'h0},
    '{K_LOAD,     6'd63, 6'd0,  32'h8000_0000, 1'b0, 48'h0},
    '{K_LOAD,     6'd1,  6'd0,  32'h0001_0000, 1'b0, 48'h0},
    '{K_PRESET,   6'd2,  6'd0,  32'h8000_0000, 1'b0, 48'h0},
    '{K_READ,     6'd2,  6'd0,  32'h0000_0000, 1'b1, 48'hFFFF_8000_0000},
    '{K_PRESET,   6'd63, 6'd0,  32'h7FFF_FFFF, 1'b0, 48'h0},
    '{K_READ,     6'd63, 6'd0,  32'h0000_0000, 1'b1, 48'h0000_7FFF_FFFF},
    '{K_MATRIX,   6'd63, 6'd63, 32'h8000_0000, 1'b0, 48'h0},
    '{K_MATRIX,   6'd63, 6'd63, 32'h8000_0000, 1'b0, 48'h0},
    '{K_MATRIX,   6'd63, 6'd63, 32'h8000_0000, 1'b0, 48'h0},
    '{K_READ,     6'd63, 6'd0,  32'h0000_0000, 1'b1, 48'h7FFF_FFFF_FFFF},
    '{K_PRESET,   6'd10, 6'd0,  32'h8000_0000, 1'b0, 48'h0},
    '{K_MATRIX,   6'd10, 6'd0,  32'h8000_0000, 1'b0, 48'h0},
    '{K_MATRIX,   6'd10, 6'd0,  32'h8000_0000, 1'b0, 48'h0},
    '{K_READ,     6'd10, 6'd0,  32'h0000_0000, 1'b1, 48'h8000_0000_0000},
    '{K_MATRIX,   6'd0,  6'd1,  32'h7FFF_FFFF, 1'b0, 48'h0},  // above diagonal
    '{K_READ,     6'd0,  6'd0,  32'h0000_0000, 1'b1, 48'h0000_0000_0000},
    '{K_MATRIX,   6'd1,  6'd0,  32'hFFFF_FFFF, 1'b0, 48'h0},  // floor of negative product
    '{K_READ,     6'd1,  6'd0,  32'h0000_0000, 1'b0, 48'h0}
  };

  lower_triangular_matvec_accumulate_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .row       (row),
    .col       (col),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_index (out_index),
    .out_sum   (out_sum),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Q16.16 product floored to Q32.16, added and clipped to 48 bits
  function automatic acc_t accumulate_product(acc_t acc, val_t a, val_t b, output bit clipped);
    logic signed [63:0] prod;
    logic signed [63:0] total;
    prod    = a * b;
    total   = acc + (prod >>> FRAC_W);
    clipped = 1'b0;
    if (total > ACC_HI) begin
      total   = ACC_HI;
      clipped = 1'b1;
    end else if (total < ACC_LO) begin
      total   = ACC_LO;
      clipped = 1'b1;
    end
    return acc_t'(total);
  endfunction

  always @(negedge clk) begin
    if (stall_reqs != stall_taken) begin
      stall_taken = stall_reqs;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // output check first, then the accepted input beat updates the predictor
  always @(posedge clk) begin : scoreboard
    readback_t want;
    bit        clipped;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (readback_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat index %0d sum %h", $time, out_index, out_sum);
        end else begin
          want = readback_q.pop_front();
          n_out++;
          if (out_index !== want.idx) begin
            errors++;
            $display("%0t: out_index mismatch expected %0d actual %0d",
                     $time, want.idx, out_index);
          end
          if (out_sum !== want.sum) begin
            errors++;
            $display("%0t: out_sum mismatch (index %0d) expected %h actual %h",
                     $time, want.idx, want.sum, out_sum);
          end
        end
      end
      if (in_valid && in_ready) begin
        n_in++;
        case (kind_t'(kind))
          K_LOAD: begin
            vec_mem[row]     = value;
            vec_written[row] = 1'b1;
          end
          K_PRESET: acc_mem[row] = acc_t'(value);
          K_MATRIX: begin
            if (col <= row && row < size_reg && col < size_reg) begin
              acc_mem[row] = accumulate_product(acc_mem[row], value, vec_mem[col], clipped);
              n_mac++;
              if (clipped) n_sat++;
            end
          end
          K_READ: begin
            want.idx = row;
            want.sum = pin_en ? pin_sum : acc_mem[row];
            readback_q.push_back(want);
          end
        endcase
      end
      if (cfg_we) size_reg = cfg_wdata;
    end
  end

  task automatic send_beat(kind_t op, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c, val_t v,
                           bit pinned, acc_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    kind     <= op;
    row      <= r;
    col      <= c;
    value    <= v;
    pin_en   <= pinned;
    pin_sum  <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic val_t pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return val_t'($urandom);
      5, 6, 7:       return val_t'(int'($urandom_range(262143)) - 131072);
      default: begin
        case ($urandom_range(4))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          default: return 32'h0001_0000;
        endcase
      end
    endcase
  endfunction

  // stall_at < 0: no long receiver hold-off in this batch
  task automatic run_random(int count, int stall_at);
    kind_t            op;
    logic [IDX_W-1:0] r, c;
    int               lim;
    int               pick;
    for (int i = 0; i < count; i++) begin
      lim  = (size_reg == 0) ? 1 : ((size_reg > NUM_ENTRIES) ? NUM_ENTRIES : int'(size_reg));
      r    = ($urandom_range(99) < 85) ? IDX_W'($urandom_range(lim - 1))
                                       : IDX_W'($urandom_range(NUM_ENTRIES - 1));
      c    = '0;
      pick = $urandom_range(99);
      if (pick < 15) begin
        op = K_LOAD;
      end else if (pick < 25) begin
        op = K_PRESET;
      end else if (pick < 75) begin
        op = K_MATRIX;
        c  = ($urandom_range(99) < 80) ? IDX_W'($urandom_range(r))
                                       : IDX_W'($urandom_range(NUM_ENTRIES - 1));
        // never touch a vector entry that has not been loaded
        if (!vec_written[c]) begin
          op = K_LOAD;
          r  = c;
        end
      end else begin
        op = K_READ;
      end
      send_beat(op, r, c, pick_value(), 1'b0, '0);
      if (i == stall_at) stall_reqs++;
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (readback_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(logic [SIZE_W-1:0] sz);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= sz;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    kind      = '0;
    row       = '0;
    col       = '0;
    value     = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    pin_en    = 1'b0;
    pin_sum   = '0;
    send_idle_pct = 9;
    recv_idle_pct = 58;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i])
      send_beat(plan[i].op, plan[i].r, plan[i].c, plan[i].v, plan[i].pinned, plan[i].sum);
    run_random(330, -1);

    settle();
    set_size(SIZE_W'(1));
    run_random(120, -1);

    settle();
    set_size(SIZE_W'(0));   // every matrix beat dropped
    run_random(50, -1);

    send_idle_pct = 58;
    recv_idle_pct = 9;
    settle();
    set_size(SIZE_W'(127)); // beyond the index range, acts as full size
    run_random(150, -1);

    settle();
    set_size(SIZE_W'($urandom_range(63, 2)));
    run_random(300, 100);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    settle();
    set_size(SIZE_W'(64));
    run_random(450, -1);

    settle();
    $display("Accepted %0d input beats, checked %0d readbacks; %0d MACs applied, %0d clipped.",
             n_in, n_out, n_mac, n_sat);
    $display("Sizes 64, 1, 0, 127, a random mid size and 64 again, with stalls on both sides.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ltmv_pkg.sv
sv/ltmv_mac.sv
sv/lower_triangular_matvec_accumulate_unit.sv
test/tb.sv
